FILE: sv/ucbp_pkg.sv
// Shared types and constants for the serial command byte parser.
// No dependencies; imported by the parser top level, its port checker and the testbench.
package ucbp_pkg;

  // Value text store: eight characters of eight bits each.
  localparam int CHAR_DEPTH = 8;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = $clog2(CHAR_DEPTH);
  localparam int CNT_W      = $clog2(CHAR_DEPTH + 1);
  localparam int TEXT_W     = CHAR_DEPTH * CHAR_W;

  // Default limit on collected value characters.
  localparam int MAX_CHARS_DEF = 8;

  // Parser states, numbered as they appear on the state output.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_READY  = 4'd1,
    ST_GET    = 4'd2,
    ST_SET    = 4'd3,
    ST_PARAM  = 4'd4,
    ST_VALUE  = 4'd5,
    ST_BUTTON = 4'd6,
    ST_TEMP   = 4'd7,
    ST_KP     = 4'd8,
    ST_KD     = 4'd9,
    ST_KI     = 4'd10,
    ST_HEATER = 4'd11,
    ST_COOLER = 4'd12
  } state_t;

  // Action codes on the result channel.
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_UP     = 3'd1,
    ACT_DOWN   = 3'd2,
    ACT_SET    = 3'd3,
    ACT_REPORT = 3'd4
  } action_t;

  // Command characters.
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  // Menu item letters.
  localparam logic [7:0] LET_T = 8'h54;
  localparam logic [7:0] LET_P = 8'h50;
  localparam logic [7:0] LET_D = 8'h44;
  localparam logic [7:0] LET_I = 8'h49;
  localparam logic [7:0] LET_C = 8'h43;

endpackage

FILE: sv/uart_command_byte_parser.sv
// Serial command byte parser: one result per received byte.
// Depends on ucbp_pkg for state and action codes and command characters.
//
// Usage:
//   Input channel in_valid / in_stall / in_rx_byte carries one received byte
//   per transfer. Result channel out_valid / out_stall carries one result per
//   byte: action, parameter letter, value text and length, parser state and
//   the PID menu flag. A transfer happens on a rising edge with valid high
//   and stall low.
//   A transferred byte lands in an input register; once the decode stage
//   advances, the parser decodes it in one pass and writes the result
//   register and its state.
//   Throughput is one byte per cycle; the decode stage advances whenever the
//   result register is empty or being taken.
//   When the receiver stalls, the result holds, the captured byte waits in
//   the input register and in_stall rises once that register is occupied.
//   Synchronous active-low reset empties both registers and returns the
//   parser to idle with all counters and flags cleared. The value character
//   store is not reset; only characters already collected are ever shown.
module uart_command_byte_parser
  import ucbp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [7:0]        out_param_letter,
  output logic [TEXT_W-1:0] out_value_text,
  output logic [3:0]        out_value_length,
  output logic [3:0]        out_parser_state,
  output logic              out_pid_menu_flag
);

  // Input register.
  logic       in_vld_r;
  logic [7:0] byte_r;

  // Parser state.
  state_t            state_r, state_nxt;
  logic [7:0]        param_r, param_nxt;
  logic [CHAR_W-1:0] chars_r [CHAR_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              button_r, button_nxt;
  logic              pid_r, pid_nxt;

  // Character store write.
  logic              chr_we;
  logic [IDX_W-1:0]  chr_idx;

  // Result register.
  logic              out_vld_r;
  action_t           act_r, act_nxt;
  logic [7:0]        let_r, let_nxt;
  logic [TEXT_W-1:0] text_r, text_nxt;
  logic [3:0]        len_r, len_nxt;

  logic advance;
  logic local_key, is_digit;
  logic menu_item;
  state_t menu_next;
  logic [7:0] menu_letter;

  // The decode stage moves when the result register is free or being taken.
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;

  // Input register capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  assign local_key = (byte_r == CH_AT) || (byte_r == CH_LT) || (byte_r == CH_GT);
  assign is_digit  = ((byte_r >= CH_0) && (byte_r <= CH_9)) || (byte_r == CH_COMMA);

  // Next state and result for the captured byte.
  always_comb begin
    state_nxt   = state_r;
    param_nxt   = param_r;
    count_nxt   = count_r;
    button_nxt  = button_r;
    pid_nxt     = pid_r;
    act_nxt     = ACT_NONE;
    let_nxt     = '0;
    text_nxt    = '0;
    len_nxt     = '0;
    chr_we      = 1'b0;
    chr_idx     = count_r[IDX_W-1:0];
    menu_item   = 1'b0;
    menu_next   = ST_IDLE;
    menu_letter = '0;

    unique case (state_r)
      ST_READY: begin
        if (byte_r == "g") begin
          state_nxt = ST_GET;
        end else if (byte_r == "s") begin
          state_nxt = ST_SET;
        end else if (!local_key) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GET: begin
        if ((byte_r == "t") || (byte_r == "c") || (byte_r == "a") ||
            (byte_r == "i") || (byte_r == "d") || (byte_r == "p") ||
            (byte_r == "b") || (byte_r == "s")) begin
          param_nxt = byte_r;
          state_nxt = ST_PARAM;
        end else if (!local_key) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SET: begin
        if ((byte_r == "c") || (byte_r == "i") || (byte_r == "d") ||
            (byte_r == "p") || (byte_r == "s")) begin
          param_nxt = byte_r;
          count_nxt = '0;
          state_nxt = ST_VALUE;
        end else if (byte_r == "b") begin
          param_nxt  = byte_r;
          button_nxt = 1'b0;
          state_nxt  = ST_BUTTON;
        end else if (!local_key) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PARAM: begin
        if (byte_r == CH_SEMI) begin
          act_nxt = ACT_REPORT;
          let_nxt = param_r;
        end
        if (!local_key) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_VALUE: begin
        if (is_digit) begin
          // Collect a character, or abort when the value is already full.
          if (count_r < CNT_W'(MAX_CHARS)) begin
            chr_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (byte_r == CH_SEMI) begin
          act_nxt = ACT_SET;
          let_nxt = param_r;
          len_nxt = 4'(count_r);
          for (int i = 0; i < CHAR_DEPTH; i++) begin
            if (CNT_W'(i) < count_r) begin
              text_nxt[i*CHAR_W +: CHAR_W] = chars_r[i];
            end
          end
          state_nxt = ST_IDLE;
        end else if (!local_key) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BUTTON: begin
        if (!button_r) begin
          if ((byte_r == CH_0) || (byte_r == CH_1)) begin
            button_nxt = 1'b1;
            chr_we     = 1'b1;
            chr_idx    = '0;
          end
        end else begin
          if (byte_r == CH_SEMI) begin
            act_nxt  = ACT_SET;
            let_nxt  = param_r;
            len_nxt  = 4'd1;
            text_nxt = TEXT_W'(chars_r[0]);
          end
          if (!local_key) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TEMP: begin
        menu_item   = 1'b1;
        menu_next   = ST_KP;
        menu_letter = LET_T;
      end
      ST_KP: begin
        menu_item   = 1'b1;
        menu_next   = ST_KD;
        menu_letter = LET_P;
      end
      ST_KD: begin
        pid_nxt     = 1'b1;
        menu_item   = 1'b1;
        menu_next   = ST_KI;
        menu_letter = LET_D;
      end
      ST_KI: begin
        menu_item   = 1'b1;
        menu_next   = ST_HEATER;
        menu_letter = LET_I;
      end
      ST_COOLER: begin
        pid_nxt     = 1'b0;
        menu_item   = 1'b1;
        menu_next   = ST_HEATER;
        menu_letter = LET_C;
      end
      ST_HEATER: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        // Idle, and any code outside the state list.
        if (byte_r == CH_HASH) begin
          state_nxt = ST_READY;
        end else if (byte_r == CH_AT) begin
          state_nxt = ST_TEMP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase

    // Shared menu item handling: '@' advances, '>' and '<' step, others abort.
    if (menu_item) begin
      if (byte_r == CH_AT) begin
        state_nxt = menu_next;
      end else if (byte_r == CH_GT) begin
        act_nxt = ACT_UP;
        let_nxt = menu_letter;
      end else if (byte_r == CH_LT) begin
        act_nxt = ACT_DOWN;
        let_nxt = menu_letter;
      end else begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // Control state update, once per decoded byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      param_r   <= '0;
      count_r   <= '0;
      button_r  <= 1'b0;
      pid_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        state_r  <= state_nxt;
        param_r  <= param_nxt;
        count_r  <= count_nxt;
        button_r <= button_nxt;
        pid_r    <= pid_nxt;
      end
    end
  end

  // Character store and result payload.
  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      if (chr_we) begin
        chars_r[chr_idx] <= byte_r;
      end
      act_r  <= act_nxt;
      let_r  <= let_nxt;
      text_r <= text_nxt;
      len_r  <= len_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_action        = act_r;
  assign out_param_letter  = let_r;
  assign out_value_text    = text_r;
  assign out_value_length  = len_r;
  assign out_parser_state  = state_r;
  assign out_pid_menu_flag = pid_r;

endmodule

FILE: sv/ucbp_checker.sv
// Port-level checker for the serial command byte parser, with its bind.
// Depends on ucbp_pkg for action and state codes.
module ucbp_checker
  import ucbp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_action,
  input logic [7:0]        out_param_letter,
  input logic [TEXT_W-1:0] out_value_text,
  input logic [3:0]        out_value_length,
  input logic [3:0]        out_parser_state
);

  // A stalled result holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_text) &&
      $stable(out_action) && $stable(out_parser_state))
    else $error("stalled result changed");

  // No result leaves the block in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Without an action there is no letter and no value.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_NONE) |->
      (out_param_letter == 8'd0) && (out_value_length == 4'd0))
    else $error("letter or value without action");

  // Only a set carries value text, and never more than the store holds.
  a_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_length <= 4'(CHAR_DEPTH)) &&
      ((out_action == ACT_SET) || (out_value_text == '0)))
    else $error("value text outside a set");

  // Menu steps leave the parser in the same menu item.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_action == ACT_UP) || (out_action == ACT_DOWN)) |->
      (out_parser_state == ST_TEMP) || (out_parser_state == ST_KP) ||
      (out_parser_state == ST_KD) || (out_parser_state == ST_KI) ||
      (out_parser_state == ST_COOLER))
    else $error("menu step outside a menu item");

endmodule

bind uart_command_byte_parser ucbp_checker u_ucbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_action       (out_action),
  .out_param_letter (out_param_letter),
  .out_value_text   (out_value_text),
  .out_value_length (out_value_length),
  .out_parser_state (out_parser_state)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial command byte parser.
// It depends on ucbp_pkg and uart_command_byte_parser; it predicts one result per byte.

module testbench;
  import ucbp_pkg::*;

  localparam int HOLD_LEN     = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOWN_ERRORS = 10;

  // Command keys that the package does not name.
  localparam logic [7:0] KEY_GET    = "g";
  localparam logic [7:0] KEY_SET    = "s";
  localparam logic [7:0] KEY_BUTTON = "b";

  // One parser result, as it appears on the result channel.
  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        letter;
    logic [TEXT_W-1:0] text;
    logic [3:0]        length;
    logic [3:0]        state;
    logic              pid;
  } parse_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_action;
  logic [7:0]        out_param_letter;
  logic [TEXT_W-1:0] out_value_text;
  logic [3:0]        out_value_length;
  logic [3:0]        out_parser_state;
  logic              out_pid_menu_flag;

  // Parameter letters accepted after a report or a set command.
  string report_keys = "tcaidpbs";
  string value_keys  = "cidps";

  // Predicted parser state.
  state_t      ps_state = ST_IDLE;
  logic [7:0]  ps_param = 8'h00;
  logic [7:0]  ps_chars [CHAR_DEPTH];
  logic [3:0]  ps_count = 4'd0;
  logic        ps_button = 1'b0;
  logic        ps_pid = 1'b0;

  parse_result_t pending_results [$];
  parse_result_t seen_result;
  parse_result_t due_result;

  int sender_idle_pct = 26;
  int receiver_stall_pct = 71;
  int hold_request = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;

  uart_command_byte_parser uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_param_letter  (out_param_letter),
    .out_value_text    (out_value_text),
    .out_value_length  (out_value_length),
    .out_parser_state  (out_parser_state),
    .out_pid_menu_flag (out_pid_menu_flag)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("FAIL uart_command_byte_parser");
      $finish;
    end
  end

  function automatic bit in_keys(input string keys, input logic [7:0] b);
    bit found;
    found = 1'b0;
    for (int k = 0; k < keys.len(); k++) begin
      if (keys[k] == b) found = 1'b1;
    end
    return found;
  endfunction

  // Menu item: '@' advances, '>' and '<' step the item, anything else leaves the menu.
  function automatic void menu_step(input logic [7:0] b, input state_t advance,
                                    input logic [7:0] item, output state_t nxt,
                                    output logic [2:0] act, output logic [7:0] letter);
    act = ACT_NONE;
    letter = 8'h00;
    if (b == CH_AT) begin
      nxt = advance;
    end else if (b == CH_GT) begin
      act = ACT_UP;
      letter = item;
      nxt = ps_state;
    end else if (b == CH_LT) begin
      act = ACT_DOWN;
      letter = item;
      nxt = ps_state;
    end else begin
      nxt = ST_IDLE;
    end
  endfunction

  // Advance the predicted parser by one byte and queue the result it gives.
  function automatic void parse_byte(input logic [7:0] b);
    parse_result_t r;
    state_t nxt;
    logic local_key;
    logic value_char;
    r = '0;
    nxt = ps_state;
    local_key = (b == CH_AT) || (b == CH_GT) || (b == CH_LT);
    value_char = ((b >= CH_0) && (b <= CH_9)) || (b == CH_COMMA);
    case (ps_state)
      ST_READY: begin
        if (b == KEY_GET) nxt = ST_GET;
        else if (b == KEY_SET) nxt = ST_SET;
        else if (!local_key) nxt = ST_IDLE;
      end
      ST_GET: begin
        if (in_keys(report_keys, b)) begin
          ps_param = b;
          nxt = ST_PARAM;
        end else if (!local_key) begin
          nxt = ST_IDLE;
        end
      end
      ST_SET: begin
        if (in_keys(value_keys, b)) begin
          ps_param = b;
          ps_count = 4'd0;
          nxt = ST_VALUE;
        end else if (b == KEY_BUTTON) begin
          ps_param = b;
          ps_button = 1'b0;
          nxt = ST_BUTTON;
        end else if (!local_key) begin
          nxt = ST_IDLE;
        end
      end
      ST_PARAM: begin
        if (b == CH_SEMI) begin
          r.action = ACT_REPORT;
          r.letter = ps_param;
        end
        if (!local_key) nxt = ST_IDLE;
      end
      ST_VALUE: begin
        if (value_char) begin
          // A character beyond the limit aborts the command.
          if (ps_count < MAX_CHARS_DEF) begin
            ps_chars[ps_count[IDX_W-1:0]] = b;
            ps_count = ps_count + 4'd1;
          end else begin
            nxt = ST_IDLE;
          end
        end else if (b == CH_SEMI) begin
          r.action = ACT_SET;
          r.letter = ps_param;
          r.length = ps_count;
          for (int i = 0; i < ps_count; i++) r.text[CHAR_W*i +: CHAR_W] = ps_chars[i];
          nxt = ST_IDLE;
        end else if (!local_key) begin
          nxt = ST_IDLE;
        end
      end
      ST_BUTTON: begin
        // Until the digit arrives, other bytes are ignored.
        if (!ps_button) begin
          if ((b == CH_0) || (b == CH_1)) begin
            ps_button = 1'b1;
            ps_chars[0] = b;
          end
        end else begin
          if (b == CH_SEMI) begin
            r.action = ACT_SET;
            r.letter = ps_param;
            r.length = 4'd1;
            r.text[CHAR_W-1:0] = ps_chars[0];
          end
          if (!local_key) nxt = ST_IDLE;
        end
      end
      ST_TEMP: menu_step(b, ST_KP, LET_T, nxt, r.action, r.letter);
      ST_KP:   menu_step(b, ST_KD, LET_P, nxt, r.action, r.letter);
      ST_KD: begin
        ps_pid = 1'b1;
        menu_step(b, ST_KI, LET_D, nxt, r.action, r.letter);
      end
      ST_KI:   menu_step(b, ST_HEATER, LET_I, nxt, r.action, r.letter);
      ST_COOLER: begin
        ps_pid = 1'b0;
        menu_step(b, ST_HEATER, LET_C, nxt, r.action, r.letter);
      end
      ST_HEATER: nxt = ST_IDLE;
      default: begin
        if (b == CH_HASH) nxt = ST_READY;
        else if (b == CH_AT) nxt = ST_TEMP;
        else nxt = ST_IDLE;
      end
    endcase
    ps_state = nxt;
    r.state = ps_state;
    r.pid = ps_pid;
    pending_results.push_back(r);
  endfunction

  function automatic logic [7:0] random_local_key();
    logic [7:0] k;
    case ($urandom_range(2))
      0: k = CH_AT;
      1: k = CH_GT;
      default: k = CH_LT;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] random_value_char();
    return ($urandom_range(10) == 10) ? CH_COMMA : CH_0 + 8'($urandom_range(9));
  endfunction

  // Offer one byte, with random idle cycles first, and wait for its transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop offering bytes until every predicted result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic note_mismatch(input string why, input parse_result_t want,
                               input parse_result_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("Mismatch at cycle %0d: %s", cycle_count, why);
      $display("  expected act %0d let %h text %h len %0d state %0d pid %b",
               want.action, want.letter, want.text, want.length, want.state, want.pid);
      $display("  actual   act %0d let %h text %h len %0d state %0d pid %b",
               got.action, got.letter, got.text, got.length, got.state, got.pid);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if ((hold_left == 0) && (hold_request != 0)) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.action = out_action;
      seen_result.letter = out_param_letter;
      seen_result.text   = out_value_text;
      seen_result.length = out_value_length;
      seen_result.state  = out_parser_state;
      seen_result.pid    = out_pid_menu_flag;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, seen_result);
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result !== due_result) note_mismatch("wrong field", due_result, seen_result);
      end
      results_checked++;
    end
  end

  // Report request with a local key ignored before the terminator.
  task automatic test_remote_report();
    send_text("#gt>;");
  endtask

  // Button set: a zero byte is ignored before the digit, '@' after it.
  task automatic test_button_set();
    send_text("#sb");
    send_byte(8'h00);
    send_byte(CH_1);
    send_byte(CH_AT);
    send_byte(CH_SEMI);
  endtask

  // Nine value characters: the last one aborts the command.
  task automatic test_value_overflow();
    send_text("#sp12345,789");
  endtask

  // Menu walk through the T, P, D and I items to heater; Kd sets the flag, heater leaves on 0xFF.
  task automatic test_local_menu();
    send_text("@>@<@>@@");
    send_byte(8'hFF);
  endtask

  // Receiver holds off while the sender keeps offering, then everything drains.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    hold_request = HOLD_LEN;
    send_text("#sd42,7;@>><<@>#gp;");
    wait_for_results();
  endtask

  // Mostly well-formed commands with random content, some broken ones and noise.
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_bytes);
    int first;
    int n;
    first = bytes_sent;
    sender_idle_pct = send_pct;
    receiver_stall_pct = recv_pct;
    while (bytes_sent - first < n_bytes) begin
      case ($urandom_range(9))
        0, 1: begin
          send_byte(CH_HASH);
          send_byte(KEY_GET);
          if ($urandom_range(9) < 8) send_byte(report_keys[$urandom_range(7)]);
          else send_byte(8'($urandom_range(255)));
          if ($urandom_range(4) == 0) send_byte(random_local_key());
          send_byte(($urandom_range(9) < 8) ? CH_SEMI : 8'($urandom_range(255)));
        end
        2, 3, 4: begin
          send_byte(CH_HASH);
          send_byte(KEY_SET);
          send_byte(($urandom_range(9) < 9) ? value_keys[$urandom_range(4)]
                                            : 8'($urandom_range(255)));
          n = ($urandom_range(9) == 0) ? $urandom_range(9, 10) : $urandom_range(8);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) send_byte(random_local_key());
            send_byte(random_value_char());
          end
          send_byte(($urandom_range(9) < 9) ? CH_SEMI : 8'($urandom_range(255)));
        end
        5, 6: begin
          send_text("#sb");
          n = $urandom_range(2);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
          send_byte(($urandom_range(1) != 0) ? CH_1 : CH_0);
          if ($urandom_range(3) == 0) send_byte(random_local_key());
          send_byte(($urandom_range(9) < 8) ? CH_SEMI : 8'($urandom_range(255)));
        end
        7, 8: begin
          send_byte(CH_AT);
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
              0, 1, 2: send_byte(CH_GT);
              3, 4, 5: send_byte(CH_LT);
              6, 7, 8: send_byte(CH_AT);
              default: send_byte(8'($urandom_range(255)));
            endcase
          end
        end
        default: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_remote_report();
    test_button_set();
    test_value_overflow();
    test_local_menu();
    wait_for_results();
    test_backpressure();

    run_random_phase(26, 71, 320);
    wait_for_results();
    run_random_phase(71, 26, 320);
    wait_for_results();
    run_random_phase(0, 0, 320);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes and checked %0d results: reports, value and button sets,",
             bytes_sent, results_checked);
    $display("overflow, menu walks and noise under gaps, stalls and a %0d-cycle hold-off.",
             HOLD_LEN);
    if ((mismatches == 0) && (pending_results.size() == 0)) begin
      $display("PASS uart_command_byte_parser");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, pending_results.size());
      $display("FAIL uart_command_byte_parser");
    end
    $finish;
  end

endmodule
